[rtl/core/itp_pkg.sv]
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NONE   = 8'h00;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNMATCHED = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } stk_cmd_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] top;
    } stk_stat_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CLASSIFY,
        SEQ_CLOSE,
        SEQ_POP,
        SEQ_FLUSH,
        SEQ_END
    } seq_state_t;

    // rank code: 0 stands for any non-operator character (lowest priority)
    function automatic logic [1:0] op_rank(input logic [7:0] c);
        logic [1:0] r;
        unique case (c) inside
            CH_CARET:           r = 2'd3;
            CH_STAR, CH_SLASH:  r = 2'd2;
            CH_PLUS, CH_MINUS:  r = 2'd1;
            default:            r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_operand(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h30) && (c <= 8'h39));
    endfunction

endpackage

[rtl/core/itp_stack.sv]
module itp_stack
    import itp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  stk_cmd_t  cmd,
    output stk_stat_t stat
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] top_pos;
    logic [7:0]       mem [STACK_DEPTH];

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[count_reg[IDX_W-1:0]] <= cmd.data;
        end
    end

    assign top_pos    = count_reg - CNT_W'(1);
    assign stat.top   = mem[top_pos[IDX_W-1:0]];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(STACK_DEPTH));

    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.full)
        else $error("push onto full operator stack");

    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.empty)
        else $error("pop from empty operator stack");

    a_single_op : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not raise the stack count");

endmodule

[rtl/core/infix_to_postfix_converter.sv]
// infix to postfix converter (shunting yard)
// in channel: in_valid/in_ready/in_item carries one character and a last flag per transfer.
// out channel: out_valid/out_ready/out_item carries one postfix character or a status-only
// result per transfer; out_last marks the final result of an expression.
// operands leave one result each; operators and brackets go through a 16-entry stack.
// a small sequencer works one character at a time: a classify step, then for an operator
// or a closing bracket a pop step per stack entry released (the single top-of-stack compare
// is reused on every pop) followed by the push or bracket drop, then a closing step in which
// the next character may already be taken. a last character adds a flush step that pops
// every remaining entry before the closing step. the newest result is held back one step so
// its last flag can be set when the character ends.
// in_ready is low while a character is being worked on.
// reset empties the stack and drops any result not yet transferred; no clearing pass.
// when the receiver stalls, the output register and the hold register fill and the
// sequencer waits; no result is lost.
module infix_to_postfix_converter
    import itp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [7:0] char_reg;
    logic       last_reg;

    logic       hold_valid_reg;
    out_item_t  hold_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;

    stk_cmd_t   stk_cmd;
    stk_stat_t  stk_stat;

    logic       accept;
    logic       slot_free;
    logic       emit_ok;
    logic       end_emit;
    logic       end_ok;
    logic       rank_ge;
    logic       top_lparen;
    logic       char_operand;
    seq_state_t after_state;

    logic       gen_en;
    logic [7:0] gen_char;
    logic [1:0] gen_status;
    logic       fin_en;

    itp_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stk_cmd),
        .stat  (stk_stat)
    );

    assign accept       = in_valid && in_ready;
    assign slot_free    = !out_valid_reg || out_ready;
    assign emit_ok      = !hold_valid_reg || slot_free;
    assign end_emit     = hold_valid_reg || last_reg;
    assign end_ok       = !end_emit || slot_free;
    assign rank_ge      = (op_rank(stk_stat.top) >= op_rank(char_reg));
    assign top_lparen   = (stk_stat.top == CH_LPAREN);
    assign char_operand = is_operand(char_reg);
    assign after_state  = last_reg ? SEQ_FLUSH : SEQ_END;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = SEQ_CLASSIFY;
                end
            end
            SEQ_CLASSIFY:
            begin
                if (char_operand)
                begin
                    if (emit_ok)
                    begin
                        state_next = after_state;
                    end
                end
                else if (char_reg == CH_LPAREN)
                begin
                    if (!stk_stat.full || emit_ok)
                    begin
                        state_next = after_state;
                    end
                end
                else if (char_reg == CH_RPAREN)
                begin
                    state_next = SEQ_CLOSE;
                end
                else
                begin
                    state_next = SEQ_POP;
                end
            end
            SEQ_CLOSE:
            begin
                if (stk_stat.empty)
                begin
                    if (emit_ok)
                    begin
                        state_next = after_state;
                    end
                end
                else if (top_lparen)
                begin
                    state_next = after_state;
                end
            end
            SEQ_POP:
            begin
                if (!(!stk_stat.empty && rank_ge))
                begin
                    if (!stk_stat.full || emit_ok)
                    begin
                        state_next = after_state;
                    end
                end
            end
            SEQ_FLUSH:
            begin
                if (stk_stat.empty)
                begin
                    state_next = SEQ_END;
                end
            end
            SEQ_END:
            begin
                if (end_ok)
                begin
                    state_next = accept ? SEQ_CLASSIFY : SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        stk_cmd    = '0;
        gen_en     = 1'b0;
        gen_char   = CH_NONE;
        gen_status = STATUS_OK;
        fin_en     = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
            end
            SEQ_CLASSIFY:
            begin
                if (char_operand)
                begin
                    gen_en   = emit_ok;
                    gen_char = char_reg;
                end
                else if (char_reg == CH_LPAREN)
                begin
                    if (stk_stat.full)
                    begin
                        gen_en     = emit_ok;
                        gen_status = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        stk_cmd.push = 1'b1;
                        stk_cmd.data = char_reg;
                    end
                end
            end
            SEQ_CLOSE:
            begin
                if (stk_stat.empty)
                begin
                    gen_en     = emit_ok;
                    gen_status = STATUS_UNMATCHED;
                end
                else if (top_lparen)
                begin
                    // matching bracket is dropped
                    stk_cmd.pop = 1'b1;
                end
                else
                begin
                    gen_en      = emit_ok;
                    gen_char    = stk_stat.top;
                    stk_cmd.pop = emit_ok;
                end
            end
            SEQ_POP:
            begin
                if (!stk_stat.empty && rank_ge)
                begin
                    gen_en      = emit_ok;
                    gen_char    = stk_stat.top;
                    stk_cmd.pop = emit_ok;
                end
                else if (stk_stat.full)
                begin
                    gen_en     = emit_ok;
                    gen_status = STATUS_OVERFLOW;
                end
                else
                begin
                    stk_cmd.push = 1'b1;
                    stk_cmd.data = char_reg;
                end
            end
            SEQ_FLUSH:
            begin
                if (!stk_stat.empty)
                begin
                    gen_en      = emit_ok;
                    gen_char    = stk_stat.top;
                    stk_cmd.pop = emit_ok;
                end
            end
            SEQ_END:
            begin
                fin_en   = end_ok;
                in_ready = end_ok;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (gen_en)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (fin_en)
            begin
                hold_valid_reg <= 1'b0;
            end
            if ((gen_en && hold_valid_reg) || (fin_en && end_emit))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= in_item.in_char;
            last_reg <= in_item.in_last;
        end
        if (gen_en)
        begin
            hold_reg.out_char <= gen_char;
            hold_reg.out_last <= 1'b0;
            hold_reg.status   <= gen_status;
        end
        // older held result moves out when a newer one arrives
        if (gen_en && hold_valid_reg)
        begin
            out_reg <= hold_reg;
        end
        else if (fin_en && end_emit)
        begin
            if (hold_valid_reg)
            begin
                out_reg.out_char <= hold_reg.out_char;
                out_reg.out_last <= last_reg;
                out_reg.status   <= hold_reg.status;
            end
            else
            begin
                // last character released nothing: status-only closing result
                out_reg.out_char <= CH_NONE;
                out_reg.out_last <= 1'b1;
                out_reg.status   <= STATUS_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_idle_hold_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_IDLE) |-> !hold_valid_reg)
        else $error("held result left over between characters");

    a_accept_classify : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == SEQ_CLASSIFY))
        else $error("accepted character not classified");

    a_status_no_char : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != STATUS_OK)) |-> (out_reg.out_char == CH_NONE))
        else $error("status result carries a character");

endmodule
